// ===== rtl/tnn_pkg.sv =====
// ----------------------------------------------------------------------------
// tnn_pkg
// Shared widths, codes and types of the two-nearest-neighbour tracker.
// ----------------------------------------------------------------------------
package tnn_pkg;

  localparam int ID_W    = 3;
  localparam int COORD_W = 16;
  localparam int REL_W   = 17;
  localparam int SQ_W    = 32;
  localparam int DIST_W  = 36;

  localparam logic [DIST_W-1:0] DIST_UNHEARD = {DIST_W{1'b1}};

  localparam logic OP_REPORT = 1'b0;
  localparam logic OP_QUERY  = 1'b1;

  typedef struct packed {
    logic signed [COORD_W-1:0] vz;
    logic signed [COORD_W-1:0] vy;
    logic signed [COORD_W-1:0] vx;
    logic signed [COORD_W-1:0] pz;
    logic signed [COORD_W-1:0] py;
    logic signed [COORD_W-1:0] px;
  } peer_rec_t;

  localparam int PEER_W = $bits(peer_rec_t);

  // request to the squared distance unit
  typedef struct packed {
    logic                    start;
    logic signed [REL_W-1:0] dx;
    logic signed [REL_W-1:0] dy;
    logic signed [REL_W-1:0] dz;
  } sqd_req_t;

endpackage

// ===== rtl/tnn_ram.sv =====
// ----------------------------------------------------------------------------
// tnn_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module tnn_ram #(
  parameter int WIDTH = 36,
  parameter int DEPTH = 8
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== rtl/tnn_sqdist.sv =====
// ----------------------------------------------------------------------------
// tnn_sqdist
// Squared distance dx*dx+dy*dy+dz*dz with one shared squarer over three steps.
// ----------------------------------------------------------------------------
module tnn_sqdist (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  tnn_pkg::sqd_req_t            req_i,
  output logic                         done_o,
  output logic [tnn_pkg::DIST_W-1:0]   dist_o
);
  import tnn_pkg::*;

  logic signed [REL_W-1:0]   d_q [3];
  logic [1:0]                step_q;
  logic                      busy_q;
  logic                      done_q;
  logic [SQ_W-1:0]           prod_q;
  logic [DIST_W-1:0]         acc_q;
  logic signed [REL_W-1:0]   d_sel;
  logic signed [2*REL_W-1:0] sq_full;

  always_comb begin
    case (step_q)
      2'd1:    d_sel = d_q[1];
      2'd2:    d_sel = d_q[2];
      default: d_sel = d_q[0];
    endcase
    sq_full = d_sel * d_sel;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= 2'd0;
      done_q <= 1'b0;
    end else begin
      done_q <= busy_q && (step_q == 2'd3);
      if (req_i.start) begin
        busy_q <= 1'b1;
        step_q <= 2'd0;
      end else if (busy_q) begin
        step_q <= step_q + 2'd1;
        if (step_q == 2'd3) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // product of one step is added in the next
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      d_q[0] <= req_i.dx;
      d_q[1] <= req_i.dy;
      d_q[2] <= req_i.dz;
      acc_q  <= '0;
    end else if (busy_q) begin
      if (step_q != 2'd3) begin
        prod_q <= sq_full[SQ_W-1:0];
      end
      if (step_q != 2'd0) begin
        acc_q <= acc_q + DIST_W'(prod_q);
      end
    end
  end

  assign done_o = done_q;
  assign dist_o = acc_q;

endmodule

// ===== rtl/tnn_rank.sv =====
// ----------------------------------------------------------------------------
// tnn_rank
// Running smallest and second smallest distance over a scan, lower index wins.
// ----------------------------------------------------------------------------
module tnn_rank #(
  parameter int IDX_W = 3
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       clear_i,
  input  logic                       valid_i,
  input  logic [IDX_W-1:0]           idx_i,
  input  logic [tnn_pkg::DIST_W-1:0] dist_i,
  output logic [IDX_W-1:0]           best_o,
  output logic [IDX_W-1:0]           second_o
);
  import tnn_pkg::*;

  // one bit above any stored distance, so the first two entries always land
  localparam logic [DIST_W:0] SENTINEL = {1'b1, {DIST_W{1'b0}}};

  logic [DIST_W:0]  m1_q, m2_q;
  logic [IDX_W-1:0] i1_q, i2_q;
  logic [DIST_W:0]  d_ext;

  assign d_ext = {1'b0, dist_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m1_q <= SENTINEL;
      m2_q <= SENTINEL;
      i1_q <= '0;
      i2_q <= '0;
    end else if (clear_i) begin
      m1_q <= SENTINEL;
      m2_q <= SENTINEL;
      i1_q <= '0;
      i2_q <= '0;
    end else if (valid_i) begin
      if (d_ext < m1_q) begin
        m2_q <= m1_q;
        i2_q <= i1_q;
        m1_q <= d_ext;
        i1_q <= idx_i;
      end else if (d_ext < m2_q) begin
        m2_q <= d_ext;
        i2_q <= idx_i;
      end
    end
  end

  assign best_o   = i1_q;
  assign second_o = i2_q;

endmodule

// ===== rtl/two_nearest_neighbor_tracker_unit.sv =====
// ----------------------------------------------------------------------------
// two_nearest_neighbor_tracker_unit
// Peer table with squared distances; tracks the two nearest peers.
//
//  channel  dir  beat contents
//  s_axis   in   report (tuser 0) or query (tuser 1) with peer and own state
//  m_axis   out  report: one beat; query: rank 0 then rank 1 (tlast)
//
//  report: accept, squared distance, a scan over every entry, then the load;
//  the scan reads the distance RAM one entry a cycle
//  query: accept, read, then two beats; two reads of the peer RAM port
//  reset clears control and the per-entry valid bits; no clearing pass
//  a stalled m_axis holds the block in its output step; input waits in idle
// ----------------------------------------------------------------------------
module two_nearest_neighbor_tracker_unit #(
  parameter int PEER_COUNT = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // drone_id, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, own_x, own_y, own_z
  input  logic [151:0] s_axis_tdata,
  // opcode
  input  logic         s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // nearest_id, second_id, rel_x, rel_y, rel_z, rel_vx, rel_vy, rel_vz
  output logic [111:0] m_axis_tdata,
  // rank
  output logic         m_axis_tuser,
  // last
  output logic         m_axis_tlast
);
  import tnn_pkg::*;

  localparam int IDX_W = $clog2(PEER_COUNT);
  localparam int CNT_W = $clog2(PEER_COUNT + 1);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_DIST    = 3'd1;
  localparam logic [2:0] S_SCAN    = 3'd2;
  localparam logic [2:0] S_REP_OUT = 3'd3;
  localparam logic [2:0] S_Q_RD    = 3'd4;
  localparam logic [2:0] S_Q_OUT0  = 3'd5;
  localparam logic [2:0] S_Q_OUT1  = 3'd6;

  logic [2:0]            state_q, state_d;

  // latched input beat
  logic [ID_W-1:0]       id_q;
  peer_rec_t             rec_q;
  logic signed [COORD_W-1:0] own_x_q, own_y_q, own_z_q;

  logic [PEER_COUNT-1:0] valid_q;
  logic [IDX_W-1:0]      nearest_q, second_q;
  logic [CNT_W-1:0]      scan_cnt_q;
  logic                  rd_v_q;
  logic [IDX_W-1:0]      rd_idx_q;
  logic                  pv_q;

  logic                  out_valid_q;
  logic [111:0]          out_data_q;
  logic                  out_user_q, out_last_q;

  logic                  in_fire, out_free, id_ok;
  sqd_req_t              sqd_req;
  logic                  sqd_done;
  logic [DIST_W-1:0]     sqd_dist;

  logic                  dist_we, dist_re;
  logic [IDX_W-1:0]      dist_raddr;
  logic [DIST_W-1:0]     dist_rdata, dist_eff;
  logic                  peer_re;
  logic [IDX_W-1:0]      peer_raddr;
  logic [PEER_W-1:0]     peer_rdata;
  peer_rec_t             peer_eff;
  logic [IDX_W-1:0]      rank_best, rank_second;
  logic                  rank_clear, scan_done;

  logic signed [COORD_W-1:0] in_px, in_py, in_pz, in_ox, in_oy, in_oz;
  logic signed [REL_W-1:0]   rel_x, rel_y, rel_z, rel_vx, rel_vy, rel_vz;

  assign in_px = s_axis_tdata[18:3];
  assign in_py = s_axis_tdata[34:19];
  assign in_pz = s_axis_tdata[50:35];
  assign in_ox = s_axis_tdata[114:99];
  assign in_oy = s_axis_tdata[130:115];
  assign in_oz = s_axis_tdata[146:131];

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;
  assign id_ok         = (32'(id_q) < 32'(PEER_COUNT));

  assign sqd_req.start = in_fire && (s_axis_tuser == OP_REPORT);
  assign sqd_req.dx    = {in_px[COORD_W-1], in_px} - {in_ox[COORD_W-1], in_ox};
  assign sqd_req.dy    = {in_py[COORD_W-1], in_py} - {in_oy[COORD_W-1], in_oy};
  assign sqd_req.dz    = {in_pz[COORD_W-1], in_pz} - {in_oz[COORD_W-1], in_oz};

  tnn_sqdist u_sqdist (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (sqd_req),
    .done_o (sqd_done),
    .dist_o (sqd_dist)
  );

  // both stores are written together when the distance is ready and the id fits the table
  assign dist_we    = (state_q == S_DIST) && sqd_done && id_ok;
  assign dist_re    = (state_q == S_SCAN) && (scan_cnt_q < CNT_W'(PEER_COUNT));
  assign dist_raddr = scan_cnt_q[IDX_W-1:0];

  tnn_ram #(.WIDTH(DIST_W), .DEPTH(PEER_COUNT)) u_dist_ram (
    .clk_i     (clk_i),
    .wr_en_i   (dist_we),
    .wr_addr_i (IDX_W'(id_q)),
    .wr_data_i (sqd_dist),
    .rd_en_i   (dist_re),
    .rd_addr_i (dist_raddr),
    .rd_data_o (dist_rdata)
  );

  assign peer_re    = (state_q == S_Q_RD) || ((state_q == S_Q_OUT0) && out_free);
  assign peer_raddr = (state_q == S_Q_RD) ? nearest_q : second_q;

  tnn_ram #(.WIDTH(PEER_W), .DEPTH(PEER_COUNT)) u_peer_ram (
    .clk_i     (clk_i),
    .wr_en_i   (dist_we),
    .wr_addr_i (IDX_W'(id_q)),
    .wr_data_i (rec_q),
    .rd_en_i   (peer_re),
    .rd_addr_i (peer_raddr),
    .rd_data_o (peer_rdata)
  );

  // unheard entries read as the largest distance and an all-zero peer record
  assign dist_eff = valid_q[rd_idx_q] ? dist_rdata : DIST_UNHEARD;
  assign peer_eff = pv_q ? peer_rec_t'(peer_rdata) : '0;

  assign rank_clear = (state_q == S_DIST) && sqd_done;
  assign scan_done  = rd_v_q && (rd_idx_q == IDX_W'(PEER_COUNT - 1));

  tnn_rank #(.IDX_W(IDX_W)) u_rank (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .clear_i  (rank_clear),
    .valid_i  (rd_v_q),
    .idx_i    (rd_idx_q),
    .dist_i   (dist_eff),
    .best_o   (rank_best),
    .second_o (rank_second)
  );

  assign rel_x  = {peer_eff.px[COORD_W-1], peer_eff.px} - {own_x_q[COORD_W-1], own_x_q};
  assign rel_y  = {peer_eff.py[COORD_W-1], peer_eff.py} - {own_y_q[COORD_W-1], own_y_q};
  assign rel_z  = {peer_eff.pz[COORD_W-1], peer_eff.pz} - {own_z_q[COORD_W-1], own_z_q};
  assign rel_vx = {peer_eff.vx[COORD_W-1], peer_eff.vx} - {rec_q.vx[COORD_W-1], rec_q.vx};
  assign rel_vy = {peer_eff.vy[COORD_W-1], peer_eff.vy} - {rec_q.vy[COORD_W-1], rec_q.vy};
  assign rel_vz = {peer_eff.vz[COORD_W-1], peer_eff.vz} - {rec_q.vz[COORD_W-1], rec_q.vz};

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          state_d = (s_axis_tuser == OP_QUERY) ? S_Q_RD : S_DIST;
        end
      end
      S_DIST: begin
        if (sqd_done) begin
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_done) begin
          state_d = S_REP_OUT;
        end
      end
      S_REP_OUT: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      S_Q_RD: begin
        state_d = S_Q_OUT0;
      end
      S_Q_OUT0: begin
        if (out_free) begin
          state_d = S_Q_OUT1;
        end
      end
      S_Q_OUT1: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      valid_q     <= '0;
      nearest_q   <= IDX_W'(0);
      second_q    <= IDX_W'(1);
      scan_cnt_q  <= '0;
      rd_v_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      rd_v_q  <= dist_re;
      if (dist_we) begin
        valid_q[IDX_W'(id_q)] <= 1'b1;
      end
      if (rank_clear) begin
        scan_cnt_q <= '0;
      end else if (dist_re) begin
        scan_cnt_q <= scan_cnt_q + CNT_W'(1);
      end
      if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      if (out_free && ((state_q == S_REP_OUT) || (state_q == S_Q_OUT0) ||
                       (state_q == S_Q_OUT1))) begin
        out_valid_q <= 1'b1;
      end
      if ((state_q == S_REP_OUT) && out_free) begin
        nearest_q <= rank_best;
        second_q  <= rank_second;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      id_q    <= s_axis_tdata[2:0];
      rec_q   <= peer_rec_t'(s_axis_tdata[98:3]);
      own_x_q <= in_ox;
      own_y_q <= in_oy;
      own_z_q <= in_oz;
    end
    if (dist_re) begin
      rd_idx_q <= dist_raddr;
    end
    if (peer_re) begin
      pv_q <= valid_q[peer_raddr];
    end
    if (out_free) begin
      if (state_q == S_REP_OUT) begin
        out_data_q <= {106'd0, ID_W'(rank_second), ID_W'(rank_best)};
        out_user_q <= 1'b0;
        out_last_q <= 1'b1;
      end else if ((state_q == S_Q_OUT0) || (state_q == S_Q_OUT1)) begin
        out_data_q <= {4'd0, rel_vz, rel_vy, rel_vx, rel_z, rel_y, rel_x,
                       ID_W'(second_q), ID_W'(nearest_q)};
        out_user_q <= (state_q == S_Q_OUT1);
        out_last_q <= (state_q == S_Q_OUT1);
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;
  assign m_axis_tlast  = out_last_q;

  a_two_distinct: assert property (@(posedge clk_i) disable iff (!rst_ni)
    nearest_q != second_q)
    else $error("nearest and second index coincide");

  a_index_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (32'(nearest_q) < 32'(PEER_COUNT)) && (32'(second_q) < 32'(PEER_COUNT)))
    else $error("tracked index beyond table");

  a_second_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
    else $error("second-rank beat without tlast");

  a_done_in_dist: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sqd_done |-> (state_q == S_DIST))
    else $error("distance finished outside its step");

  a_scan_then_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    scan_done |=> (state_q == S_REP_OUT))
    else $error("scan end not followed by report beat");

endmodule

// ===== bench/two_nearest_neighbor_tracker_unit_test.sv =====
// ----------------------------------------------------------------------------
// two_nearest_neighbor_tracker_unit_test
// Drives peer reports and queries into the tracker over the input stream.
// Each accepted beat is mirrored in a scoreboard that keeps its own peer
// table and distance ranking. Every output beat is checked field by field
// against the expected beats, oldest first. Both sides idle at random, and
// the output side holds off once for a long stretch.
// ----------------------------------------------------------------------------
module two_nearest_neighbor_tracker_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import tnn_pkg::*;

  localparam int NUM_PEERS   = 8;
  localparam int RANDOM_BEATS = 530;
  localparam int CALM_BEATS  = 80;
  localparam int HOLD_CYCLES = 300;

  typedef struct packed {
    logic signed [COORD_W-1:0] z;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] x;
  } vec3_t;

  // same order as m_axis: last, rank, then tdata from the top down
  typedef struct packed {
    logic                    last;
    logic                    rank;
    logic signed [REL_W-1:0] rel_vz;
    logic signed [REL_W-1:0] rel_vy;
    logic signed [REL_W-1:0] rel_vx;
    logic signed [REL_W-1:0] rel_z;
    logic signed [REL_W-1:0] rel_y;
    logic signed [REL_W-1:0] rel_x;
    logic [ID_W-1:0]         second_id;
    logic [ID_W-1:0]         nearest_id;
  } track_beat_t;

  class tracker_scoreboard;
    logic [DIST_W-1:0] dist_tab[NUM_PEERS];
    vec3_t             pos_tab[NUM_PEERS];
    vec3_t             vel_tab[NUM_PEERS];
    int                near_idx;
    int                sec_idx;
    track_beat_t       expected_q[$];
    int                err_count;
    int                reports_seen;
    int                queries_seen;
    int                beats_checked;

    function new();
      for (int i = 0; i < NUM_PEERS; i++) begin
        dist_tab[i] = DIST_UNHEARD;
        pos_tab[i]  = '0;
        vel_tab[i]  = '0;
      end
      near_idx = 0;
      sec_idx  = 1;
    endfunction

    function void note_input(logic op, logic [151:0] d);
      logic [ID_W-1:0]   id;
      vec3_t             pos;
      vec3_t             vel;
      vec3_t             own;
      longint            dx;
      longint            dy;
      longint            dz;
      logic [DIST_W-1:0] m1;
      logic [DIST_W-1:0] m2;
      int                i1;
      int                i2;
      int                idx;
      track_beat_t       b;
      id  = d[2:0];
      pos = d[50:3];
      vel = d[98:51];
      own = d[146:99];
      if (op == OP_REPORT) begin
        reports_seen++;
        pos_tab[id] = pos;
        vel_tab[id] = vel;
        dx = $signed(pos.x) - $signed(own.x);
        dy = $signed(pos.y) - $signed(own.y);
        dz = $signed(pos.z) - $signed(own.z);
        dist_tab[id] = DIST_W'(dx * dx + dy * dy + dz * dz);
        // rescan, ties stay with the lower index
        i1 = 0;
        i2 = 1;
        m1 = dist_tab[0];
        m2 = dist_tab[1];
        if (m1 > m2) begin
          m1 = dist_tab[1];
          m2 = dist_tab[0];
          i1 = 1;
          i2 = 0;
        end
        for (int i = 2; i < NUM_PEERS; i++) begin
          if (dist_tab[i] < m1) begin
            m2 = m1;
            i2 = i1;
            m1 = dist_tab[i];
            i1 = i;
          end else if (dist_tab[i] < m2) begin
            m2 = dist_tab[i];
            i2 = i;
          end
        end
        near_idx = i1;
        sec_idx  = i2;
        b = '0;
        b.nearest_id = ID_W'(near_idx);
        b.second_id  = ID_W'(sec_idx);
        b.last       = 1'b1;
        expected_q.push_back(b);
      end else begin
        queries_seen++;
        for (int k = 0; k < 2; k++) begin
          idx = (k == 0) ? near_idx : sec_idx;
          b.nearest_id = ID_W'(near_idx);
          b.second_id  = ID_W'(sec_idx);
          b.rank   = (k == 1);
          b.last   = (k == 1);
          b.rel_x  = $signed(pos_tab[idx].x) - $signed(own.x);
          b.rel_y  = $signed(pos_tab[idx].y) - $signed(own.y);
          b.rel_z  = $signed(pos_tab[idx].z) - $signed(own.z);
          b.rel_vx = $signed(vel_tab[idx].x) - $signed(vel.x);
          b.rel_vy = $signed(vel_tab[idx].y) - $signed(vel.y);
          b.rel_vz = $signed(vel_tab[idx].z) - $signed(vel.z);
          expected_q.push_back(b);
        end
      end
    endfunction

    function void check_field(string name, longint exp_v, longint act_v);
      if (exp_v != act_v) begin
        err_count++;
        $display("%0t: %s mismatch, expected %0d actual %0d", $realtime, name, exp_v, act_v);
      end
    endfunction

    function void check_result(logic [111:0] d, logic rank, logic last);
      track_beat_t act;
      track_beat_t exp_b;
      act = {last, rank, d[107:0]};
      if (expected_q.size() == 0) begin
        err_count++;
        $display("%0t: output beat with nothing expected, expected none actual %h",
                 $realtime, act);
        return;
      end
      exp_b = expected_q.pop_front();
      beats_checked++;
      check_field("nearest_id", exp_b.nearest_id, act.nearest_id);
      check_field("second_id", exp_b.second_id, act.second_id);
      check_field("rank", exp_b.rank, act.rank);
      check_field("rel_x", exp_b.rel_x, act.rel_x);
      check_field("rel_y", exp_b.rel_y, act.rel_y);
      check_field("rel_z", exp_b.rel_z, act.rel_z);
      check_field("rel_vx", exp_b.rel_vx, act.rel_vx);
      check_field("rel_vy", exp_b.rel_vy, act.rel_vy);
      check_field("rel_vz", exp_b.rel_vz, act.rel_vz);
      check_field("last", exp_b.last, act.last);
    endfunction
  endclass

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [151:0] s_axis_tdata;
  logic         s_axis_tuser;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [111:0] m_axis_tdata;
  logic         m_axis_tuser;
  logic         m_axis_tlast;

  tracker_scoreboard sb = new();
  bit calm_phase;
  bit hold_request;
  bit hold_done;

  two_nearest_neighbor_tracker_unit #(
    .PEER_COUNT(NUM_PEERS)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #3ms;
    $display("simulation failed");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) sb.note_input(s_axis_tuser, s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) begin
        sb.check_result(m_axis_tdata, m_axis_tuser, m_axis_tlast);
      end
    end
  end

  // output side: random stall bursts, one long hold-off on request
  initial begin
    int stall_left;
    stall_left = 0;
    m_axis_tready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      if (hold_request) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_request = 1'b0;
        hold_done    = 1'b1;
      end else if (calm_phase) begin
        m_axis_tready <= 1'b1;
      end else if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else if ($urandom_range(0, 6) == 0) begin
        m_axis_tready <= 1'b0;
        stall_left = $urandom_range(1, 6) - 1;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  function automatic vec3_t v3(int x, int y, int z);
    vec3_t v;
    v.x = COORD_W'(x);
    v.y = COORD_W'(y);
    v.z = COORD_W'(z);
    return v;
  endfunction

  function automatic vec3_t rand_vec();
    return v3($urandom_range(0, 65535), $urandom_range(0, 65535), $urandom_range(0, 65535));
  endfunction

  // called at a falling edge, returns at a falling edge
  task automatic send_beat(input logic op, input logic [2:0] id, input vec3_t pos,
                           input vec3_t vel, input vec3_t own);
    int gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {5'b0, own, vel, pos, id};
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
    if (!calm_phase && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 6);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  initial begin
    vec3_t own;
    vec3_t pos;
    vec3_t vel;
    vec3_t last_pos;
    vec3_t lo;
    vec3_t hi;
    vec3_t mid;
    logic  op;
    int    mode;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = OP_REPORT;
    calm_phase    = 1'b0;
    hold_request  = 1'b0;
    hold_done     = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    lo  = v3(-32768, -32768, -32768);
    hi  = v3(32767, 32767, 32767);
    mid = v3(100, -200, 300);

    // queries on an empty table read the all-zero store
    send_beat(OP_QUERY, 3'd5, rand_vec(), hi, lo);
    send_beat(OP_QUERY, 3'd2, rand_vec(), lo, hi);
    // farthest possible peer, then a tie at that distance
    send_beat(OP_REPORT, 3'd7, hi, hi, lo);
    send_beat(OP_QUERY, 3'd0, rand_vec(), lo, lo);
    send_beat(OP_REPORT, 3'd2, lo, lo, hi);
    send_beat(OP_QUERY, 3'd0, rand_vec(), hi, hi);
    // zero-distance peers, lower index wins each tie
    send_beat(OP_REPORT, 3'd3, mid, v3(1, 2, 3), mid);
    send_beat(OP_REPORT, 3'd5, mid, v3(-1, -2, -3), mid);
    send_beat(OP_REPORT, 3'd1, mid, hi, mid);
    send_beat(OP_QUERY, 3'd7, rand_vec(), v3(0, 0, 0), mid);
    send_beat(OP_REPORT, 3'd0, mid, lo, mid);
    send_beat(OP_REPORT, 3'd4, v3(101, -200, 300), rand_vec(), mid);
    send_beat(OP_REPORT, 3'd6, v3(100, -199, 299), rand_vec(), mid);
    send_beat(OP_QUERY, 3'd1, rand_vec(), rand_vec(), mid);
    // move nearest peers away again
    send_beat(OP_REPORT, 3'd0, hi, rand_vec(), lo);
    send_beat(OP_REPORT, 3'd1, v3(5000, 5000, 5000), rand_vec(), mid);
    send_beat(OP_QUERY, 3'd3, rand_vec(), lo, v3(0, 0, 0));
    send_beat(OP_REPORT, 3'd3, v3(0, 0, 0), v3(0, 0, 0), v3(0, 0, 0));
    send_beat(OP_QUERY, 3'd4, rand_vec(), hi, lo);

    own      = mid;
    last_pos = mid;
    for (int n = 0; n < RANDOM_BEATS; n++) begin
      if (n == 200) hold_request = 1'b1;
      if (n == RANDOM_BEATS - CALM_BEATS) calm_phase = 1'b1;
      if ($urandom_range(0, 15) == 0) begin
        own = rand_vec();
      end else begin
        own = v3(int'(own.x) + int'($urandom_range(0, 40)) - 20,
                 int'(own.y) + int'($urandom_range(0, 40)) - 20,
                 int'(own.z) + int'($urandom_range(0, 40)) - 20);
      end
      op   = ($urandom_range(0, 9) < 3) ? OP_QUERY : OP_REPORT;
      mode = $urandom_range(0, 7);
      case (mode)
        0, 1: pos = rand_vec();
        // same spot as the most recent report
        2: pos = last_pos;
        3: pos = ($urandom_range(0, 1) == 0) ? hi : lo;
        default: begin
          pos = v3(int'(own.x) + int'($urandom_range(0, 512)) - 256,
                   int'(own.y) + int'($urandom_range(0, 512)) - 256,
                   int'(own.z) + int'($urandom_range(0, 512)) - 256);
        end
      endcase
      vel = ($urandom_range(0, 7) == 0) ? (($urandom_range(0, 1) == 0) ? hi : lo) : rand_vec();
      send_beat(op, 3'($urandom_range(0, 7)), pos, vel, own);
      if (op == OP_REPORT) last_pos = pos;
    end
    s_axis_tvalid <= 1'b0;

    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (NUM_PEERS + 20) @(posedge clk_i);

    $display("covered %0d reports and %0d queries, %0d output beats checked",
             sb.reports_seen, sb.queries_seen, sb.beats_checked);
    $display("random idling on both sides, long output hold-off done: %0d", hold_done);
    if (sb.err_count == 0 && sb.expected_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
